>>> hw/rtl/rqfs_pkg.sv
// Shared types and constants for the request queue (first-come or shortest-first).
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rqfs_pkg;

   localparam int DEPTH     = 16;
   localparam int SIZE_BITS = 32;

   localparam int CONN_W   = 10;
   localparam int HANDLE_W = 16;
   localparam int FSIZE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int CAP_W    = 5;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   localparam logic POLICY_FIFO     = 1'b0;
   localparam logic POLICY_SHORTEST = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_REJECT = 2'd2,
      OP_EMPTY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COMPARE = 2'd1,
      ST_UPDATE  = 2'd2
   } state_type;

   typedef struct packed {
      logic [CONN_W-1:0]    conn;
      logic [HANDLE_W-1:0]  handle;
      logic [SIZE_BITS-1:0] size;
   } entry_type;

   typedef struct packed {
      logic   load;
      logic   compare;
      logic   update;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic dequeue;
      logic full;
      logic empty;
   } stat_type;

endpackage

>>> hw/rtl/rqfs_ctrl.sv
// Controller state machine for the request queue: load, compare, update.
// Depends on rqfs_pkg; drives the datapath through cmd_type and reads stat_type.
`timescale 1ns / 1ps

module rqfs_ctrl
   import rqfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.update  = 1'b0;
      cmd.op      = OP_INSERT;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (stat.dequeue) begin
               cmd.op = stat.empty ? OP_EMPTY : OP_REMOVE;
            end else begin
               cmd.op = stat.full ? OP_REJECT : OP_INSERT;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/rqfs_datapath.sv
// Datapath of the request queue: a row of entry cells with per-cell size compare,
// configuration registers, request latch and result registers. Depends on rqfs_pkg.
`timescale 1ns / 1ps

module rqfs_datapath
   import rqfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_mode,
   input  logic [CONN_W-1:0]    req_conn_id,
   input  logic [HANDLE_W-1:0]  req_file_handle,
   input  logic [FSIZE_W-1:0]   req_file_size,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [CONN_W-1:0]    rsp_head_conn,
   output logic [HANDLE_W-1:0]  rsp_head_handle,
   output logic [FSIZE_W-1:0]   rsp_head_size,
   output logic [OCC_W-1:0]     rsp_occupancy
);

   localparam logic [DEPTH-1:0] ONES = {DEPTH{1'b1}};

   logic             policy_ff;
   logic [CAP_W-1:0] capacity_ff;

   logic      mode_ff;
   entry_type req_ff;

   entry_type  entry_ff [DEPTH];
   entry_type  entry_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [DEPTH-1:0] found_ff, found_in;
   logic [DEPTH-1:0] below;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   entry_type           rsp_head_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cap_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_FIFO;
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLICY:   policy_ff   <= csr_wdata[0];
            CSR_CAPACITY: capacity_ff <= csr_wdata[CAP_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff       <= req_mode;
         req_ff.conn   <= req_conn_id;
         req_ff.handle <= req_file_handle;
         req_ff.size   <= SIZE_BITS'(req_file_size);
      end
   end

   // Full when the count reaches the capacity register or the physical depth.
   assign cnt_ext      = CMP_W'(count_ff);
   assign cap_ext      = CMP_W'(capacity_ff);
   assign stat.full    = (cnt_ext >= cap_ext) || (cnt_ext >= CMP_W'(DEPTH));
   assign stat.empty   = (count_ff == '0);
   assign stat.dequeue = (mode_ff == MODE_DEQUEUE);

   // In shortest-first mode each held cell flags if the new entry goes before it.
   // The count-position cell always flags, so the first flag is the insertion point.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cmp
      logic held;
      logic goes_before;
      assign held = (CNT_W'(gi) < count_ff);
      if (gi == 0) begin : g_head
         assign goes_before = (req_ff.size < entry_ff[gi].size);
      end else begin : g_rest
         assign goes_before = !(req_ff.size > entry_ff[gi].size);
      end
      assign found_in[gi] = (CNT_W'(gi) == count_ff) ||
                            ((policy_ff == POLICY_SHORTEST) && held && goes_before);
      assign below[gi] = |(found_ff & (ONES >> (DEPTH - gi)));
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         found_ff <= found_in;
      end
   end

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      always_comb begin
         entry_in[gi] = entry_ff[gi];
         if (cmd.op == OP_REMOVE) begin
            if (gi < DEPTH - 1) begin
               entry_in[gi] = entry_ff[(gi < DEPTH - 1) ? gi + 1 : gi];
            end
         end else if (below[gi]) begin
            entry_in[gi] = entry_ff[(gi > 0) ? gi - 1 : gi];
         end else if (found_ff[gi]) begin
            entry_in[gi] = req_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && ((cmd.op == OP_INSERT) || (cmd.op == OP_REMOVE))) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.update) begin
         case (cmd.op)
            OP_INSERT: count_in = count_ff + CNT_W'(1);
            OP_REMOVE: count_in = count_ff - CNT_W'(1);
            default:   count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_count_ff <= count_in;
         case (cmd.op)
            OP_REMOVE: begin
               rsp_status_ff <= STATUS_DONE;
               rsp_head_ff   <= entry_ff[0];
            end
            OP_REJECT: begin
               rsp_status_ff <= STATUS_FULL;
               rsp_head_ff   <= '0;
            end
            OP_EMPTY: begin
               rsp_status_ff <= STATUS_EMPTY;
               rsp_head_ff   <= '0;
            end
            default: begin
               rsp_status_ff <= STATUS_DONE;
               rsp_head_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_conn   = rsp_head_ff.conn;
   assign rsp_head_handle = rsp_head_ff.handle;
   assign rsp_head_size   = FSIZE_W'(rsp_head_ff.size);
   assign rsp_occupancy   = OCC_W'(rsp_count_ff);

endmodule

>>> hw/rtl/request_queue_fifo_or_shortest_first_top.sv
// Request queue, first-come or shortest-first order. A request is taken when start
// is high and busy is low; its result strobes on rsp_valid after the load, compare
// and update states. No new request is taken until then. Load latches the request,
// compare registers the parallel size compare of all cells, update shifts the cells.
// The receiver cannot stall. Synchronous reset empties the queue, sets policy to
// first-come and capacity to 16; entry contents are not cleared.
`timescale 1ns / 1ps

module request_queue_fifo_or_shortest_first_top
   import rqfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [CONN_W-1:0]    req_conn_id,
   input  logic [HANDLE_W-1:0]  req_file_handle,
   input  logic [FSIZE_W-1:0]   req_file_size,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [CONN_W-1:0]    rsp_head_conn,
   output logic [HANDLE_W-1:0]  rsp_head_handle,
   output logic [FSIZE_W-1:0]   rsp_head_size,
   output logic [OCC_W-1:0]     rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   rqfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rqfs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mode        (req_mode),
      .req_conn_id     (req_conn_id),
      .req_file_handle (req_file_handle),
      .req_file_size   (req_file_size),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_conn   (rsp_head_conn),
      .rsp_head_handle (rsp_head_handle),
      .rsp_head_size   (rsp_head_size),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule
